FILE: sv/det_pkg.sv
// ----------------------------------------------------------------------------
// det_pkg: shared types and constants for the debounced event timestamper.
// Holds the input event codes, the reply job descriptor and the character
// codes used in serial replies and frames.
// ----------------------------------------------------------------------------
package det_pkg;

  // Default parameter values.
  localparam int DefCountBits = 24;
  localparam int DefDebounce  = 5;

  // Depth of the job queue between the front and the back part.
  localparam int QueueDepth = 4;

  // Number of timestamp bits carried in a change frame.
  localparam int StampBits = 24;

  // Input event kinds.
  typedef enum logic [1:0] {
    CMD_FINE   = 2'd0,
    CMD_DEB    = 2'd1,
    CMD_PIN    = 2'd2,
    CMD_SERIAL = 2'd3
  } cmd_t;

  // Kinds of byte sequence the back part sends.
  typedef enum logic [2:0] {
    JOB_FRAME   = 3'd0,
    JOB_STATUS  = 3'd1,
    JOB_JUMP    = 3'd2,
    JOB_VERSION = 3'd3,
    JOB_PERIOD  = 3'd4,
    JOB_ERROR   = 3'd5
  } job_kind_t;

  // One queued reply or frame.
  typedef struct packed {
    job_kind_t              kind;
    logic [7:0]             arg;
    logic [StampBits-1:0]   stamp;
    logic                   led;
  } job_t;

  // Character codes.
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Index of the final byte of a job.
  function automatic logic [2:0] job_last_idx(job_kind_t kind);
    logic [2:0] idx;
    unique case (kind)
      JOB_FRAME:   idx = 3'd4;
      JOB_VERSION: idx = 3'd3;
      JOB_ERROR:   idx = 3'd2;
      default:     idx = 3'd1;
    endcase
    return idx;
  endfunction

endpackage

FILE: sv/det_front.sv
// ----------------------------------------------------------------------------
// det_front: event front end.
// While accept is high, applies one input event per cycle to the timer,
// debounce and command state, and queues at most one reply or frame job.
// ----------------------------------------------------------------------------
module det_front #(
  parameter int         COUNT_BITS       = det_pkg::DefCountBits,
  parameter logic [7:0] DEFAULT_DEBOUNCE = 8'(det_pkg::DefDebounce)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  det_pkg::cmd_t cmd,
  input  logic          pin_level,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output det_pkg::job_t job
);
  import det_pkg::*;

  localparam int LowBits = COUNT_BITS - 8;

  logic                  in_debounce, in_debounce_next;
  logic [COUNT_BITS-1:0] interval_count, interval_count_next;
  logic [COUNT_BITS-1:0] event_stamp, event_stamp_next;
  logic [7:0]            debounce_left, debounce_left_next;
  logic [7:0]            debounce_period, debounce_period_next;
  logic                  stable_level, stable_level_next;
  logic                  first_pending, first_pending_next;
  logic                  await_period_byte, await_period_byte_next;

  logic                  level;
  logic [LowBits-1:0]    tick_low;
  logic [7:0]            tick_top;
  logic [COUNT_BITS-1:0] add_base;
  logic [COUNT_BITS-1:0] restore_sum;
  logic [31:0]           stamp_wide;
  logic                  job_valid;

  // Logical level of the active-low contact.
  assign level = ~pin_level;

  // Fine tick: low part wraps, top byte counts up and holds at its maximum.
  always_comb begin
    tick_low = interval_count[LowBits-1:0];
    tick_top = interval_count[COUNT_BITS-1:LowBits];
    if (&tick_low) begin
      tick_low = '0;
      if (!(&tick_top)) begin
        tick_top = tick_top + 8'd1;
      end
    end else begin
      tick_low = tick_low + LowBits'(1);
    end
  end

  // A debounce only ends on a debounce tick or a pin change; after a pin
  // change the counter has just been cleared.
  assign add_base    = (cmd == CMD_PIN) ? '0 : interval_count;
  assign restore_sum = add_base + event_stamp_next;
  assign stamp_wide  = 32'(event_stamp_next);

  // Next state and job for the current event.
  always_comb begin
    in_debounce_next       = in_debounce;
    interval_count_next    = interval_count;
    event_stamp_next       = event_stamp;
    debounce_left_next     = debounce_left;
    debounce_period_next   = debounce_period;
    stable_level_next      = stable_level;
    first_pending_next     = first_pending;
    await_period_byte_next = await_period_byte;
    job_valid              = 1'b0;
    job                    = '0;

    unique case (cmd)
      CMD_FINE: begin
        interval_count_next = {tick_top, tick_low};
      end
      CMD_DEB: begin
        if (debounce_left != 8'd0) begin
          debounce_left_next = debounce_left - 8'd1;
        end
      end
      CMD_PIN: begin
        if (!in_debounce) begin
          event_stamp_next    = first_pending ? '0 : interval_count;
          interval_count_next = '0;
          first_pending_next  = 1'b0;
          debounce_left_next  = debounce_period;
          in_debounce_next    = 1'b1;
        end
      end
      CMD_SERIAL: begin
        if (await_period_byte) begin
          debounce_period_next   = rx_byte;
          await_period_byte_next = 1'b0;
        end else begin
          job_valid = 1'b1;
          priority case (rx_byte)
            CH_E: begin
              job.kind = JOB_STATUS;
              job.arg  = {7'd0, stable_level};
            end
            CH_J: job.kind = JOB_JUMP;
            CH_V: job.kind = JOB_VERSION;
            CH_A: begin
              job.kind = JOB_PERIOD;
              job.arg  = debounce_period + CH_ZERO;
            end
            CH_B: begin
              job_valid              = 1'b0;
              await_period_byte_next = 1'b1;
            end
            default: job.kind = JOB_ERROR;
          endcase
        end
      end
      default: ;
    endcase

    // End of debounce: confirm the change or put the time back.
    if (in_debounce_next && debounce_left_next == 8'd0) begin
      in_debounce_next = 1'b0;
      if (level == stable_level) begin
        interval_count_next = restore_sum;
      end else begin
        stable_level_next = level;
        job_valid         = 1'b1;
        job.kind          = JOB_FRAME;
        job.arg           = {7'd0, level};
        job.stamp         = stamp_wide[StampBits-1:0];
      end
    end

    job.led = ~stable_level_next;
  end

  assign push = accept && job_valid;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_debounce       <= 1'b0;
      interval_count    <= '0;
      event_stamp       <= '0;
      debounce_left     <= DEFAULT_DEBOUNCE;
      debounce_period   <= DEFAULT_DEBOUNCE;
      stable_level      <= 1'b0;
      first_pending     <= 1'b1;
      await_period_byte <= 1'b0;
    end else if (accept) begin
      in_debounce       <= in_debounce_next;
      interval_count    <= interval_count_next;
      event_stamp       <= event_stamp_next;
      debounce_left     <= debounce_left_next;
      debounce_period   <= debounce_period_next;
      stable_level      <= stable_level_next;
      first_pending     <= first_pending_next;
      await_period_byte <= await_period_byte_next;
    end
  end

endmodule

FILE: sv/det_queue.sv
// ----------------------------------------------------------------------------
// det_queue: job queue.
// A small first-in first-out buffer of reply and frame jobs that lets the
// front and the back part stall independently.
// ----------------------------------------------------------------------------
module det_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  det_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output det_pkg::job_t head_job
);
  import det_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  job_t               slots [QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   count;

  assign full       = (count == (PtrBits+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      priority if (push && !pop) begin
        count <= count + (PtrBits+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PtrBits+1)'(1);
      end
    end
  end

endmodule

FILE: sv/det_back.sv
// ----------------------------------------------------------------------------
// det_back: byte sender.
// Takes one job at a time from the queue and sends its bytes, one per
// transfer, marking the final byte of each reply or frame.
// ----------------------------------------------------------------------------
module det_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  det_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    tx_byte,
  output logic          last_byte,
  output logic          led_on
);
  import det_pkg::*;

  logic       cur_valid;
  job_t       cur;
  logic [2:0] idx;

  assign out_valid = cur_valid;
  assign last_byte = (idx == job_last_idx(cur.kind));
  assign led_on    = cur.led;
  assign pop       = head_valid && (!cur_valid || (out_ready && last_byte));

  // Byte of the current job at the current position.
  always_comb begin
    tx_byte = CH_NL;
    unique case (cur.kind)
      JOB_FRAME: begin
        unique case (idx)
          3'd0:    tx_byte = CH_X;
          3'd1:    tx_byte = cur.arg;
          3'd2:    tx_byte = cur.stamp[23:16];
          3'd3:    tx_byte = cur.stamp[15:8];
          default: tx_byte = cur.stamp[7:0];
        endcase
      end
      JOB_STATUS:  tx_byte = (idx == 3'd0) ? CH_E : cur.arg;
      JOB_JUMP:    tx_byte = (idx == 3'd0) ? CH_J : CH_NL;
      JOB_VERSION: begin
        unique case (idx)
          3'd0, 3'd2: tx_byte = CH_ONE;
          3'd1:       tx_byte = CH_DOT;
          default:    tx_byte = CH_NL;
        endcase
      end
      JOB_PERIOD:  tx_byte = (idx == 3'd0) ? cur.arg : CH_NL;
      JOB_ERROR: begin
        unique case (idx)
          3'd0:    tx_byte = CH_DASH;
          3'd1:    tx_byte = CH_ONE;
          default: tx_byte = CH_NL;
        endcase
      end
      default: tx_byte = CH_NL;
    endcase
  end

  // Job register and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (cur_valid && out_ready) begin
      if (last_byte) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

endmodule

FILE: sv/debounced_event_timestamper.sv
// ----------------------------------------------------------------------------
// debounced_event_timestamper: debounced contact change timestamper.
// Input events are fine ticks, debounce ticks, pin changes and serial
// command bytes; output is the serial byte stream of frames and replies.
//
// Slave channel: one event per transfer, kind in s_tuser, pin level and
// received byte in s_tdata. Master channel: one serial byte per transfer,
// with m_tlast on the final byte of each frame or reply.
// Events are taken one per cycle while the job queue (4 entries) has room;
// an event is applied to the timer and debounce state in the cycle it is
// taken. A frame or reply is registered in the queue, then in the sender's
// job register, and goes out one byte per cycle while m_tready is high.
// When the receiver stalls, the sender holds its byte, the queue fills, and
// s_tready drops only once the queue is full; events that cause no bytes
// still pass whenever there is room.
// Reset clears the counters and the queue and loads the default debounce
// period; the first pin change after reset is stamped zero.
// ----------------------------------------------------------------------------
module debounced_event_timestamper #(
  parameter int         COUNT_BITS       = det_pkg::DefCountBits,
  parameter logic [7:0] DEFAULT_DEBOUNCE = 8'(det_pkg::DefDebounce)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] pin_level, [8:1] rx_byte, [15:9] zero
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] tx_byte, [8] led_on, [15:9] zero
  output logic        m_tlast
);
  import det_pkg::*;

  logic       accept;
  logic       push;
  job_t       push_job;
  logic       full;
  logic       pop;
  logic       head_valid;
  job_t       head_job;
  logic [7:0] tx_byte;
  logic       led_on;

  assign s_tready = ~full;
  assign accept   = s_tvalid && s_tready;

  // Front end: applies events and emits jobs.
  det_front #(
    .COUNT_BITS      (COUNT_BITS),
    .DEFAULT_DEBOUNCE(DEFAULT_DEBOUNCE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd_t'(s_tuser)),
    .pin_level(s_tdata[0]),
    .rx_byte  (s_tdata[8:1]),
    .push     (push),
    .job      (push_job)
  );

  // Job queue.
  det_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // Byte sender.
  det_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .tx_byte   (tx_byte),
    .last_byte (m_tlast),
    .led_on    (led_on)
  );

  assign m_tdata = {7'd0, led_on, tx_byte};

  // After a push, the queue head is valid in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> head_valid)
    else $error("queued job missing at queue head");

  // The sender only takes a job that is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job taken from empty queue");

  // The output goes idle only after the final byte of a job was taken.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> ($past(m_tlast && m_tready) || $past(rst)))
    else $error("output dropped in the middle of a job");

endmodule
